[rtl/iew_pkg.sv]
// ----------------------------------------------------------------------------
// iew_pkg: integer to English words, shared types and codes
// Word codes for the output channel and the BCD working widths.
// ----------------------------------------------------------------------------
`default_nettype none

package iew_pkg;

  typedef logic [5:0] word_t;
  typedef logic [3:0] digit_t;

  localparam word_t W_ZERO      = 6'd0;
  localparam word_t W_TEN       = 6'd10;
  localparam word_t W_TENS_BASE = 6'd18;
  localparam word_t W_HUNDRED   = 6'd28;
  localparam word_t W_THOUSAND  = 6'd29;
  localparam word_t W_MILLION   = 6'd30;
  localparam word_t W_BILLION   = 6'd31;
  localparam word_t W_NEGATIVE  = 6'd32;

  localparam int VALUE_W  = 32;
  localparam int DIGITS   = 12;          // four groups of three digits
  localparam int BCD_W    = DIGITS * 4;
  localparam int GROUP_W  = 12;

endpackage

`default_nettype wire

[rtl/integer_to_english_words.sv]
// ----------------------------------------------------------------------------
// integer_to_english_words: spell a signed 32-bit integer as word codes
// Double-dabble conversion one bit per cycle, then a group walk that emits
// one word per cycle at most.
// ----------------------------------------------------------------------------
// Usage: pulse start with in_value while busy is low. The magnitude is shifted
// through a 48-bit BCD register one bit per cycle, then the four digit groups
// are walked five steps each. Busy stays high throughout, and a new number
// can be taken only once busy is low again. Words come out on out_word with
// out_strobe high for exactly one cycle each; out_last marks the final word,
// which shows in the first cycle that busy is low again.
// The receiver cannot stall, so it must take every strobed word. Up to 17
// words per number (Negative first for values below zero, Zero alone for 0).
`default_nettype none

module integer_to_english_words (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire signed [31:0]   in_value,
  output logic                out_strobe,
  output iew_pkg::word_t      out_word,
  output logic                out_last
);

  import iew_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [2:0] SP_HUND_DIGIT = 3'd0;
  localparam logic [2:0] SP_HUND_WORD  = 3'd1;
  localparam logic [2:0] SP_TENS       = 3'd2;
  localparam logic [2:0] SP_UNITS      = 3'd3;
  localparam logic [2:0] SP_SCALE      = 3'd4;

  logic [1:0]         state_r, state_nxt;
  logic [4:0]         bit_cnt_r, bit_cnt_nxt;
  logic [1:0]         grp_r, grp_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic               pend_vld_r, pend_vld_nxt;
  word_t              pend_word_r, pend_word_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  word_t              out_word_r, out_word_nxt;
  logic               out_last_r, out_last_nxt;

  digit_t             dig_h, dig_t, dig_u;
  logic               grp_nz;
  logic               emit_vld;
  word_t              emit_word;

  // add-3 on every digit that is 5 or more, ahead of the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ?
                          bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  // top group of the BCD register is the one being spelled
  assign dig_h  = bcd_r[BCD_W-1 -: 4];
  assign dig_t  = bcd_r[BCD_W-5 -: 4];
  assign dig_u  = bcd_r[BCD_W-9 -: 4];
  assign grp_nz = (dig_h != 4'd0) || (dig_t != 4'd0) || (dig_u != 4'd0);

  always_comb begin
    emit_vld  = 1'b0;
    emit_word = W_ZERO;
    unique case (step_r)
      SP_HUND_DIGIT: begin
        emit_vld  = (dig_h != 4'd0);
        emit_word = {2'b00, dig_h};
      end
      SP_HUND_WORD: begin
        emit_vld  = (dig_h != 4'd0);
        emit_word = W_HUNDRED;
      end
      SP_TENS: begin
        if (dig_t >= 4'd2) begin
          emit_vld  = 1'b1;
          emit_word = W_TENS_BASE + {2'b00, dig_t};
        end else if (dig_t == 4'd1) begin
          emit_vld  = 1'b1;
          emit_word = W_TEN + {2'b00, dig_u};
        end
      end
      SP_UNITS: begin
        emit_vld  = (dig_t != 4'd1) && (dig_u != 4'd0);
        emit_word = {2'b00, dig_u};
      end
      SP_SCALE: begin
        emit_vld  = grp_nz && (grp_r != 2'd3);
        emit_word = W_BILLION - {4'b0000, grp_r};
      end
      default: begin
        emit_vld  = 1'b0;
        emit_word = W_ZERO;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    bit_cnt_nxt    = bit_cnt_r;
    grp_nxt        = grp_r;
    step_nxt       = step_r;
    mag_nxt        = mag_r;
    bcd_nxt        = bcd_r;
    pend_vld_nxt   = pend_vld_r;
    pend_word_nxt  = pend_word_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    out_last_nxt   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt   = ST_CONV;
          bit_cnt_nxt = 5'd31;
          bcd_nxt     = '0;
          grp_nxt     = 2'd0;
          step_nxt    = SP_HUND_DIGIT;
          mag_nxt     = in_value[31] ? (~in_value) + 32'd1 : in_value;
          // the first word is known up front: Negative, Zero, or none yet
          if (in_value[31]) begin
            pend_vld_nxt  = 1'b1;
            pend_word_nxt = W_NEGATIVE;
          end else if (in_value == 32'sd0) begin
            pend_vld_nxt  = 1'b1;
            pend_word_nxt = W_ZERO;
          end else begin
            pend_vld_nxt  = 1'b0;
          end
        end
      end
      ST_CONV: begin
        {bcd_nxt, mag_nxt} = {bcd_adj[BCD_W-2:0], mag_r, 1'b0};
        bit_cnt_nxt        = bit_cnt_r - 5'd1;
        if (bit_cnt_r == 5'd0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // words go out one behind, so the final one can carry last
        if (step_r == SP_SCALE && grp_r == 2'd3) begin
          out_strobe_nxt = pend_vld_r;
          out_word_nxt   = pend_word_r;
          out_last_nxt   = 1'b1;
          pend_vld_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          if (emit_vld) begin
            out_strobe_nxt = pend_vld_r;
            out_word_nxt   = pend_word_r;
            pend_vld_nxt   = 1'b1;
            pend_word_nxt  = emit_word;
          end
          if (step_r == SP_SCALE) begin
            step_nxt = SP_HUND_DIGIT;
            grp_nxt  = grp_r + 2'd1;
            bcd_nxt  = {bcd_r[BCD_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt_r   <= bit_cnt_nxt;
    grp_r       <= grp_nxt;
    step_r      <= step_nxt;
    mag_r       <= mag_nxt;
    bcd_r       <= bcd_nxt;
    pend_word_r <= pend_word_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;
  assign out_last   = out_last_r;

  a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe)
    else $error("last flag without word strobe");

  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word <= W_NEGATIVE))
    else $error("word code out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted number did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("final word while still busy");

  a_no_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> busy)
    else $error("word strobe outside a number");

endmodule

`default_nettype wire
